// ===== hdl/nlat_pkg.sv =====
`default_nettype none
package nlat_pkg;

  localparam int TableDepth = 16;
  localparam int KeyBits    = 32;
  localparam int SlotBits   = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntBits    = 16;

  typedef logic [SlotBits-1:0] slot_t;

  typedef enum logic [2:0] {
    OP_ADD    = 3'd0,
    OP_UPDATE = 3'd1,
    OP_REMOVE = 3'd2,
    OP_FIND   = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    EV_ACK       = 3'd0,
    EV_NEW       = 3'd1,
    EV_REMOVED   = 3'd2,
    EV_TARDY     = 3'd3,
    EV_STALE     = 3'd4,
    EV_RETIRED   = 3'd5,
    EV_TICK_DONE = 3'd6
  } ev_t;

  typedef enum logic [1:0] {
    CFG_TARDY  = 2'd0,
    CFG_STALE  = 2'd1,
    CFG_RETIRE = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OP,
    ST_TICK,
    ST_DONE,
    ST_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input beat
    logic scan_clr;  // reset slot pointer and search flags
    logic scan_step; // examine slot at pointer, advance
    logic do_op;     // apply add/update/remove/find result
    logic tick_step; // age slot at pointer, may produce a result
    logic tick_done; // produce closing tick result
    logic pop;       // output holding register taken
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_tick;
    logic ptr_last;
    logic emitted;   // tick_step produced a result
  } sts_t;

endpackage
`default_nettype wire

// ===== hdl/node_liveness_aging_table_unit.sv =====
`default_nettype none
// Node liveness aging table.
// Input stream: one beat per command (add, update, remove, find, tick) with a
// node id and type. Output stream: result beats, tlast on the final one of
// each command. Config: cfg_we/cfg_addr/cfg_wdata write tardy (0), stale (1)
// and retire (2) thresholds; write only while idle.
// Flow: a lookup walks the table one slot per cycle over all TableDepth
// slots; for add/update/remove/find the result is then applied and
// registered, and the result beat is held in the output register until taken.
// A tick first sets up, then visits one slot per cycle, pausing at each
// reporting slot until its result beat is taken; after the last slot the
// tick-done beat is registered and offered.
// One command is in flight at a time; in_tready is high only when idle, so
// the next input beat can be taken in the cycle after the last result beat leaves.
// Output is held in a register; while out_tready is low the walk pauses
// and the beat stays stable. Nothing is lost when the receiver stalls.
// Reset (rst_n low, synchronous) empties the table and restores the
// thresholds to 6, 10 and 20. No clearing pass is needed.
module node_liveness_aging_table_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [55:0] in_tdata,   // operation[2:0], node_id[34:3], node_type[50:35]
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata,  // event_res[2:0], ok[3], result_id[35:4],
                                  // result_type[51:36]
  output logic        out_tlast,
  input  wire         cfg_we,
  input  wire  [1:0]  cfg_addr,
  input  wire  [15:0] cfg_wdata
);

  nlat_pkg::cmd_t cmd;
  nlat_pkg::sts_t sts;
  logic [2:0]  ev;
  logic        ok;
  logic [31:0] rid;
  logic [15:0] rtype;

  nlat_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tready(out_tready), .out_tvalid(out_tvalid), .sts(sts), .cmd(cmd)
  );

  nlat_dp u_dp (
    .clk(clk), .rst_n(rst_n), .op_in(in_tdata[2:0]), .id_in(in_tdata[34:3]),
    .type_in(in_tdata[50:35]), .cfg_we(cfg_we), .cfg_addr(cfg_addr),
    .cfg_wdata(cfg_wdata), .cmd(cmd), .sts(sts), .ev_o(ev), .ok_o(ok),
    .id_o(rid), .type_o(rtype), .last_o(out_tlast)
  );

  assign out_tdata = {4'd0, rtype, rid, ok, ev};

endmodule
`default_nettype wire

// ===== hdl/nlat_ctrl.sv =====
`default_nettype none
module nlat_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              in_tvalid,
  output logic             in_tready,
  input  wire              out_tready,
  output logic             out_tvalid,
  input  nlat_pkg::sts_t   sts,
  output nlat_pkg::cmd_t   cmd
);

  nlat_pkg::state_t state_r, state_nxt;
  nlat_pkg::state_t ret_r, ret_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nlat_pkg::ST_IDLE;
      ret_r   <= nlat_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    ret_nxt    = ret_r;
    cmd        = '0;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    unique case (state_r)
      nlat_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load     = 1'b1;
          cmd.scan_clr = 1'b1;
          state_nxt    = nlat_pkg::ST_SCAN;
        end
      end
      nlat_pkg::ST_SCAN: begin
        if (sts.is_tick) begin
          state_nxt = nlat_pkg::ST_TICK;
        end else begin
          cmd.scan_step = 1'b1;
          if (sts.ptr_last) state_nxt = nlat_pkg::ST_OP;
        end
      end
      nlat_pkg::ST_OP: begin
        cmd.do_op = 1'b1;
        ret_nxt   = nlat_pkg::ST_IDLE;
        state_nxt = nlat_pkg::ST_OUT;
      end
      nlat_pkg::ST_TICK: begin
        cmd.tick_step = 1'b1;
        if (sts.emitted) begin
          ret_nxt   = sts.ptr_last ? nlat_pkg::ST_DONE : nlat_pkg::ST_TICK;
          state_nxt = nlat_pkg::ST_OUT;
        end else if (sts.ptr_last) begin
          state_nxt = nlat_pkg::ST_DONE;
        end
      end
      nlat_pkg::ST_DONE: begin
        cmd.tick_done = 1'b1;
        ret_nxt       = nlat_pkg::ST_IDLE;
        state_nxt     = nlat_pkg::ST_OUT;
      end
      nlat_pkg::ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.pop   = 1'b1;
          state_nxt = ret_r;
        end
      end
      default: state_nxt = nlat_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== hdl/nlat_dp.sv =====
`default_nettype none
module nlat_dp (
  input  wire                clk,
  input  wire                rst_n,
  input  wire  [2:0]         op_in,
  input  wire  [31:0]        id_in,
  input  wire  [15:0]        type_in,
  input  wire                cfg_we,
  input  wire  [1:0]         cfg_addr,
  input  wire  [15:0]        cfg_wdata,
  input  nlat_pkg::cmd_t     cmd,
  output nlat_pkg::sts_t     sts,
  output logic [2:0]         ev_o,
  output logic               ok_o,
  output logic [31:0]        id_o,
  output logic [15:0]        type_o,
  output logic               last_o
);

  localparam int D = nlat_pkg::TableDepth;
  localparam int K = nlat_pkg::KeyBits;
  localparam int S = nlat_pkg::SlotBits;

  logic [15:0] tardy_r, stale_r, retire_r;
  logic [D-1:0] valid_r, valid_nxt;
  logic [K-1:0]  key_r  [D];
  logic [15:0]   kind_r [D];
  logic [15:0]   cnt_r  [D];

  logic [2:0]  op_r;
  logic [K-1:0] key_in_r;
  logic [15:0] type_in_r;
  logic [S-1:0] ptr_r;
  logic        hit_r, free_r;
  logic [S-1:0] hit_slot_r, free_slot_r;

  logic [K-1:0] key_c;
  logic [15:0]  cnt_c;
  logic         v_c;

  always_comb begin
    key_c = key_r[ptr_r];
    cnt_c = cnt_r[ptr_r];
    v_c   = valid_r[ptr_r];
  end

  assign sts.is_tick  = (op_r == 3'(nlat_pkg::OP_TICK));
  assign sts.ptr_last = (ptr_r == S'(D - 1));
  assign sts.emitted  = v_c && ((cnt_c >= retire_r) || (cnt_c == tardy_r) ||
                                (cnt_c == stale_r));

  always_comb begin
    valid_nxt = valid_r;
    if (cmd.do_op) begin
      if (op_r == 3'(nlat_pkg::OP_ADD)) begin
        if (hit_r) valid_nxt[hit_slot_r] = 1'b1;
        else if (free_r) valid_nxt[free_slot_r] = 1'b1;
      end else if (op_r == 3'(nlat_pkg::OP_REMOVE) && hit_r) begin
        valid_nxt[hit_slot_r] = 1'b0;
      end
    end
    if (cmd.tick_step && v_c && cnt_c >= retire_r) valid_nxt[ptr_r] = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tardy_r  <= 16'd6;
      stale_r  <= 16'd10;
      retire_r <= 16'd20;
      valid_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          2'(nlat_pkg::CFG_TARDY):  tardy_r  <= cfg_wdata;
          2'(nlat_pkg::CFG_STALE):  stale_r  <= cfg_wdata;
          2'(nlat_pkg::CFG_RETIRE): retire_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= op_in;
      key_in_r  <= K'(id_in);
      type_in_r <= type_in;
    end
    if (cmd.scan_clr) begin
      ptr_r  <= '0;
      hit_r  <= 1'b0;
      free_r <= 1'b0;
    end
    if (cmd.scan_step) begin
      if (v_c && key_c == key_in_r && !hit_r) begin
        hit_r      <= 1'b1;
        hit_slot_r <= ptr_r;
      end
      if (!v_c && !free_r) begin
        free_r      <= 1'b1;
        free_slot_r <= ptr_r;
      end
      if (!sts.ptr_last) ptr_r <= ptr_r + 1'b1;
    end
    if (cmd.do_op) begin
      last_o <= 1'b1;
      id_o   <= 32'(key_in_r);
      unique case (op_r)
        3'(nlat_pkg::OP_ADD): begin
          if (hit_r || free_r) begin
            ev_o   <= nlat_pkg::EV_NEW;
            ok_o   <= 1'b1;
            type_o <= type_in_r;
            key_r [hit_r ? hit_slot_r : free_slot_r] <= key_in_r;
            kind_r[hit_r ? hit_slot_r : free_slot_r] <= type_in_r;
            cnt_r [hit_r ? hit_slot_r : free_slot_r] <= '0;
          end else begin
            ev_o   <= nlat_pkg::EV_ACK;
            ok_o   <= 1'b0;
            type_o <= '0;
          end
        end
        3'(nlat_pkg::OP_UPDATE), 3'(nlat_pkg::OP_FIND): begin
          ev_o   <= nlat_pkg::EV_ACK;
          ok_o   <= hit_r;
          type_o <= hit_r ? kind_r[hit_slot_r] : 16'd0;
          if (hit_r && op_r == 3'(nlat_pkg::OP_UPDATE)) cnt_r[hit_slot_r] <= '0;
        end
        3'(nlat_pkg::OP_REMOVE): begin
          ev_o   <= hit_r ? nlat_pkg::EV_REMOVED : nlat_pkg::EV_ACK;
          ok_o   <= hit_r;
          type_o <= hit_r ? kind_r[hit_slot_r] : 16'd0;
        end
        default: begin
          ev_o   <= nlat_pkg::EV_ACK;
          ok_o   <= 1'b0;
          type_o <= '0;
        end
      endcase
    end
    if (cmd.tick_step) begin
      if (v_c) begin
        ok_o   <= 1'b1;
        last_o <= 1'b0;
        id_o   <= 32'(key_c);
        type_o <= kind_r[ptr_r];
        if (cnt_c >= retire_r) ev_o <= nlat_pkg::EV_RETIRED;
        else if (cnt_c == tardy_r) ev_o <= nlat_pkg::EV_TARDY;
        else ev_o <= nlat_pkg::EV_STALE;
        if (cnt_c < retire_r && cnt_c != 16'hFFFF) cnt_r[ptr_r] <= cnt_c + 16'd1;
      end
      if (!sts.ptr_last) ptr_r <= ptr_r + 1'b1;
    end
    if (cmd.tick_done) begin
      ev_o   <= nlat_pkg::EV_TICK_DONE;
      ok_o   <= 1'b1;
      id_o   <= '0;
      type_o <= '0;
      last_o <= 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/nlat_checker.sv =====
`default_nettype none
module nlat_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_tready,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [55:0] out_tdata,
  input wire        out_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output beat changed under stall");

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while result pending");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2:0] == nlat_pkg::EV_TICK_DONE |-> out_tlast)
    else $error("tick done without tlast");

  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[55:52] == 4'd0)
    else $error("padding not zero");

endmodule

bind node_liveness_aging_table_unit nlat_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tlast(out_tlast)
);
`default_nettype wire
